/* rtl/esp_pkg.sv */
// ----------------------------------------------------------------------------
// esp_pkg: shared definitions for the encoder speed PID ramp block
// Widths, register indexes, multiplier and accumulator command codes, and the
// structs that join the controller, the datapath and the register file.
// ----------------------------------------------------------------------------
package esp_pkg;

  // Counter readings are CNT_W bits wide; the counter modulus is 2**CNT_W.
  localparam int CNT_W = 16;

  // Output ramp length in fast ticks; the divide by it is an arithmetic
  // shift, so it is a power of two.
  localparam int RAMP_STEPS = 4;
  localparam int RAMP_SHIFT = $clog2(RAMP_STEPS);
  localparam int STEP_W     = $clog2(RAMP_STEPS + 1);

  // Channel widths.
  localparam int IN_DW  = 48;
  localparam int OUT_DW = 16;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 21;

  // Register indexes.
  localparam logic [CFG_AW-1:0] REG_VEL_LIMIT  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DERIV_GAIN = 3'd3;
  localparam logic [CFG_AW-1:0] REG_INTEG_MAX  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_INTEG_MIN  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_DRIVE_MAX  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_DRIVE_MIN  = 3'd7;

  // Low-pass filter weights: 0.7 and 0.3 in Q.8, the new-sample weight
  // already scaled by 256 because the speed enters as an integer.
  localparam logic signed [15:0] FILT_OLD = 16'sd179;
  localparam logic signed [15:0] FILT_NEW = 16'sd19712;

  // Multiplier operand selection.
  localparam logic [2:0] MUL_NONE    = 3'd0;
  localparam logic [2:0] MUL_FV_OLD  = 3'd1;
  localparam logic [2:0] MUL_SPD_NEW = 3'd2;
  localparam logic [2:0] MUL_FV_KP   = 3'd3;
  localparam logic [2:0] MUL_INT_KI  = 3'd4;
  localparam logic [2:0] MUL_D_KD    = 3'd5;
  localparam logic [2:0] MUL_RAMP    = 3'd6;

  // Accumulator operations.
  localparam logic [2:0] ACC_HOLD     = 3'd0;
  localparam logic [2:0] ACC_LD_RND8  = 3'd1;
  localparam logic [2:0] ACC_LD_RND16 = 3'd2;
  localparam logic [2:0] ACC_ADD      = 3'd3;
  localparam logic [2:0] ACC_ADD_SH8  = 3'd4;

  typedef struct packed {
    logic        [9:0]  vel_limit;
    logic signed [15:0] prop_gain;
    logic signed [15:0] integ_gain;
    logic signed [15:0] deriv_gain;
    logic        [19:0] integral_max;
    logic signed [20:0] integral_min;
    logic        [14:0] drive_max;
    logic signed [15:0] drive_min;
  } esp_cfg_t;

  typedef struct packed {
    logic       in_load;
    logic       sum_upd;
    logic       speed_upd;
    logic [2:0] mul_sel;
    logic [2:0] acc_op;
    logic       fv_upd;
    logic       int_upd;
    logic       drv_upd;
    logic       out_load;
  } esp_cmd_t;

  typedef struct packed {
    logic slow;
  } esp_sts_t;

endpackage

/* rtl/esp_cfg.sv */
// ----------------------------------------------------------------------------
// esp_cfg: configuration register file
// Holds the eight control registers and takes one write per cycle.
// ----------------------------------------------------------------------------
module esp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [esp_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [esp_pkg::CFG_DW-1:0]  cfg_data,
  output esp_pkg::esp_cfg_t           cfg
);
  import esp_pkg::*;

  esp_cfg_t regs_r;

  assign cfg_ready = 1'b1;
  assign cfg       = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.vel_limit    <= 10'd100;
      regs_r.prop_gain    <= '0;
      regs_r.integ_gain   <= '0;
      regs_r.deriv_gain   <= '0;
      regs_r.integral_max <= 20'hFFFFF;
      regs_r.integral_min <= 21'h100000;
      regs_r.drive_max    <= 15'h7FFF;
      regs_r.drive_min    <= 16'h8000;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_VEL_LIMIT:  regs_r.vel_limit    <= cfg_data[9:0];
        REG_PROP_GAIN:  regs_r.prop_gain    <= cfg_data[15:0];
        REG_INTEG_GAIN: regs_r.integ_gain   <= cfg_data[15:0];
        REG_DERIV_GAIN: regs_r.deriv_gain   <= cfg_data[15:0];
        REG_INTEG_MAX:  regs_r.integral_max <= cfg_data[19:0];
        REG_INTEG_MIN:  regs_r.integral_min <= cfg_data[20:0];
        REG_DRIVE_MAX:  regs_r.drive_max    <= cfg_data[14:0];
        REG_DRIVE_MIN:  regs_r.drive_min    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/esp_ctrl.sv */
// ----------------------------------------------------------------------------
// esp_ctrl: sequencing state machine
// Steps the datapath through the sum, filter, integral, PID and ramp phases
// (filter to PID on slow ticks only) and owns both stream channel handshakes.
// ----------------------------------------------------------------------------
module esp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  esp_pkg::esp_sts_t sts,
  output esp_pkg::esp_cmd_t cmd
);
  import esp_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SUM   = 4'd1;
  localparam logic [3:0] ST_SPEED = 4'd2;
  localparam logic [3:0] ST_F0    = 4'd3;
  localparam logic [3:0] ST_F1    = 4'd4;
  localparam logic [3:0] ST_F2    = 4'd5;
  localparam logic [3:0] ST_F3    = 4'd6;
  localparam logic [3:0] ST_INTG  = 4'd7;
  localparam logic [3:0] ST_P0    = 4'd8;
  localparam logic [3:0] ST_P1    = 4'd9;
  localparam logic [3:0] ST_P2    = 4'd10;
  localparam logic [3:0] ST_P3    = 4'd11;
  localparam logic [3:0] ST_P4    = 4'd12;
  localparam logic [3:0] ST_RAMP  = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.in_load = 1'b1;
          state_nxt   = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum_upd = 1'b1;
        state_nxt   = sts.slow ? ST_SPEED : ST_RAMP;
      end
      ST_SPEED: begin
        cmd.speed_upd = 1'b1;
        state_nxt     = ST_F0;
      end
      ST_F0: begin
        cmd.mul_sel = MUL_FV_OLD;
        state_nxt   = ST_F1;
      end
      ST_F1: begin
        cmd.mul_sel = MUL_SPD_NEW;
        cmd.acc_op  = ACC_LD_RND8;
        state_nxt   = ST_F2;
      end
      ST_F2: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_F3;
      end
      ST_F3: begin
        cmd.fv_upd = 1'b1;
        state_nxt  = ST_INTG;
      end
      ST_INTG: begin
        cmd.int_upd = 1'b1;
        state_nxt   = ST_P0;
      end
      ST_P0: begin
        cmd.mul_sel = MUL_FV_KP;
        state_nxt   = ST_P1;
      end
      ST_P1: begin
        cmd.mul_sel = MUL_INT_KI;
        cmd.acc_op  = ACC_LD_RND16;
        state_nxt   = ST_P2;
      end
      ST_P2: begin
        cmd.mul_sel = MUL_D_KD;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = ST_P3;
      end
      ST_P3: begin
        cmd.acc_op = ACC_ADD_SH8;
        state_nxt  = ST_P4;
      end
      ST_P4: begin
        cmd.drv_upd = 1'b1;
        state_nxt   = ST_RAMP;
      end
      ST_RAMP: begin
        cmd.mul_sel = MUL_RAMP;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // The ramp product is kept selected so that it stays valid while
        // this item waits for the result register.
        cmd.mul_sel = MUL_RAMP;
        // The result register frees up either when empty or when its
        // current item is taken in this same cycle.
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/esp_dp.sv */
// ----------------------------------------------------------------------------
// esp_dp: controller datapath
// Encoder sums, filter, integral and drive state, one shared signed
// multiplier with a registered product, an accumulator, and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module esp_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [esp_pkg::IN_DW-1:0]    in_tdata,
  input  logic                         in_tuser,
  input  esp_pkg::esp_cfg_t            cfg,
  input  esp_pkg::esp_cmd_t            cmd,
  output esp_pkg::esp_sts_t            sts,
  output logic [esp_pkg::OUT_DW-1:0]   out_tdata,
  output logic                         out_tuser
);
  import esp_pkg::*;

  localparam logic [CNT_W:0] CNT_MOD  = {1'b1, {CNT_W{1'b0}}};
  localparam logic [CNT_W:0] CNT_HALF = CNT_MOD >> 1;

  // Latched input item.
  logic        [CNT_W-1:0] lraw_r, rraw_r;
  logic signed [10:0]      tgt_r;
  logic                    slow_r;

  // Controller state.
  logic signed [23:0]      lsum_r, rsum_r;
  logic signed [24:0]      last_r, speed_r;
  logic signed [25:0]      d_r;
  logic signed [32:0]      fv_r;
  logic signed [28:0]      integ_r;
  logic signed [31:0]      dold_r, dnew_r;
  logic        [STEP_W-1:0] step_r;

  // Arithmetic pipeline.
  logic signed [48:0]      prod_r;
  logic signed [51:0]      acc_r;
  logic        [15:0]      vdrive_r;
  logic                    sat_r;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v[24] != v[23]) begin
      return v[24] ? 24'sh800000 : 24'sh7FFFFF;
    end
    return v[23:0];
  endfunction

  assign sts.slow  = slow_r;
  assign out_tdata = vdrive_r;
  assign out_tuser = sat_r;

  // Fold the readings into signed deltas; the left one is mirrored first.
  logic        [CNT_W:0] lm, ld_u, rd_u;
  logic signed [24:0]    lsum_c, rsum_c;
  always_comb begin
    lm     = CNT_MOD - {1'b0, lraw_r};
    ld_u   = (lm >= CNT_HALF) ? lm - CNT_MOD : lm;
    rd_u   = ({1'b0, rraw_r} >= CNT_HALF) ? {1'b0, rraw_r} - CNT_MOD : {1'b0, rraw_r};
    lsum_c = 25'(lsum_r) + 25'($signed(ld_u));
    rsum_c = 25'(rsum_r) + 25'($signed(rd_u));
  end

  logic signed [24:0] spd_c;
  logic signed [25:0] d_c;
  assign spd_c = 25'(lsum_r) + 25'(rsum_r);
  assign d_c   = 26'(spd_c) - 26'(last_r);

  // Shared multiplier.
  logic signed [32:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [32:0] diff_c;
  logic [STEP_W-1:0]  stp1;
  assign diff_c = 33'(dnew_r) - 33'(dold_r);
  assign stp1   = step_r + STEP_W'(1);

  always_comb begin
    case (cmd.mul_sel)
      MUL_FV_OLD: begin
        mul_a = fv_r;
        mul_b = FILT_OLD;
      end
      MUL_SPD_NEW: begin
        mul_a = 33'(speed_r);
        mul_b = FILT_NEW;
      end
      MUL_FV_KP: begin
        mul_a = fv_r;
        mul_b = cfg.prop_gain;
      end
      MUL_INT_KI: begin
        mul_a = 33'(integ_r);
        mul_b = cfg.integ_gain;
      end
      MUL_D_KD: begin
        mul_a = 33'(d_r);
        mul_b = cfg.deriv_gain;
      end
      MUL_RAMP: begin
        mul_a = diff_c;
        mul_b = $signed(16'(stp1));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic signed [51:0] prod_x;
  assign prod_x = 52'(prod_r);

  // Filter result: rounded Q.16 sum down to Q.8, saturated to 33 bits.
  logic signed [43:0] fsh;
  logic signed [32:0] fv_c;
  always_comb begin
    fsh = acc_r[51:8];
    if (fsh[43:32] != {12{fsh[32]}}) begin
      fv_c = fsh[43] ? 33'sh1_0000_0000 : 33'sh0_FFFF_FFFF;
    end else begin
      fv_c = fsh[32:0];
    end
  end

  // Drive result: rounded Q.16 down to integer, saturated to 32 bits.
  logic signed [35:0] dsh;
  logic signed [31:0] drv_c;
  always_comb begin
    dsh = acc_r[51:16];
    if (dsh[35:31] != {5{dsh[31]}}) begin
      drv_c = dsh[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      drv_c = dsh[31:0];
    end
  end

  // Target clamp and integral update with its two-sided clamp.
  logic signed [11:0] lim12, tgt12, tc;
  logic signed [34:0] isum, imax35, imin35, ic;
  always_comb begin
    lim12 = $signed({2'b00, cfg.vel_limit});
    tgt12 = 12'(tgt_r);
    tc    = (tgt12 > lim12) ? lim12 : tgt12;
    if (tc < -lim12) begin
      tc = -lim12;
    end
    isum   = 35'(integ_r) + 35'(fv_r) - (35'(tc) <<< 8);
    imax35 = $signed({7'b0, cfg.integral_max, 8'b0});
    imin35 = 35'(cfg.integral_min) <<< 8;
    ic     = (isum > imax35) ? imax35 : isum;
    if (ic < imin35) begin
      ic = imin35;
    end
  end

  // Ramp point: quotient truncated toward zero, then saturated.
  logic signed [48:0] qb, q, o, dmax49, dmin49, oc;
  logic               flag_c;
  always_comb begin
    qb     = prod_r[48] ? prod_r + 49'(RAMP_STEPS - 1) : prod_r;
    q      = qb >>> RAMP_SHIFT;
    o      = 49'(dold_r) + q;
    dmax49 = $signed({34'b0, cfg.drive_max});
    dmin49 = 49'(cfg.drive_min);
    oc     = o;
    flag_c = 1'b0;
    if (oc >= dmax49) begin
      oc     = dmax49;
      flag_c = 1'b1;
    end
    if (oc <= dmin49) begin
      oc     = dmin49;
      flag_c = 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      lraw_r <= in_tdata[15:0];
      rraw_r <= in_tdata[31:16];
      tgt_r  <= in_tdata[42:32];
      slow_r <= in_tuser;
    end
    prod_r <= mul_a * mul_b;
    case (cmd.acc_op)
      ACC_LD_RND8:  acc_r <= prod_x + 52'sd128;
      ACC_LD_RND16: acc_r <= prod_x + 52'sd32768;
      ACC_ADD:      acc_r <= acc_r + prod_x;
      ACC_ADD_SH8:  acc_r <= acc_r + (prod_x <<< 8);
      default:      acc_r <= acc_r;
    endcase
    if (cmd.out_load) begin
      vdrive_r <= oc[15:0];
      sat_r    <= flag_c;
    end
  end

  // Controller state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsum_r  <= '0;
      rsum_r  <= '0;
      last_r  <= '0;
      speed_r <= '0;
      d_r     <= '0;
      fv_r    <= '0;
      integ_r <= '0;
      dold_r  <= '0;
      dnew_r  <= '0;
      step_r  <= '0;
    end else begin
      if (cmd.sum_upd) begin
        lsum_r <= sat24(lsum_c);
        rsum_r <= sat24(rsum_c);
      end
      if (cmd.speed_upd) begin
        speed_r <= spd_c;
        d_r     <= d_c;
        last_r  <= spd_c;
        lsum_r  <= '0;
        rsum_r  <= '0;
      end
      if (cmd.fv_upd) begin
        fv_r <= fv_c;
      end
      if (cmd.int_upd) begin
        integ_r <= ic[28:0];
      end
      if (cmd.drv_upd) begin
        dold_r <= dnew_r;
        dnew_r <= drv_c;
      end
      if (cmd.out_load) begin
        step_r <= (stp1 >= STEP_W'(RAMP_STEPS)) ? '0 : stp1;
      end
    end
  end

endmodule

/* rtl/encoder_speed_pid_ramp.sv */
// ----------------------------------------------------------------------------
// encoder_speed_pid_ramp: encoder speed PID controller with output ramp
// Folds two quadrature counter readings into speed sums, runs a filtered
// PID speed loop on slow ticks, and ramps the drive toward each new value.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  --------  ---------  -------------------------------------------------------
//  in_       sink       tdata: left_count_raw, right_count_raw, target_speed
//                       tuser: slow_tick
//  out_      source     tdata: velocity_drive; tuser: drive_saturated
//  cfg_      sink       addr: register index 0..7; data: register value
//
//  Without slow_tick an item passes the sum, ramp and output states; with
//  slow_tick the speed, filter, integral and PID states come after the sum. The
//  shared multiplier gives two products for the filter, three for the PID
//  sum and one for the ramp, one per cycle. in_tready is high only while idle.
//  Reset is synchronous and clears all controller state. A result not taken
//  holds the next item at its final step; config is taken every cycle.
//
module encoder_speed_pid_ramp (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input items.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [15:0] left_count_raw, [31:16] right_count_raw,
  // [42:32] target_speed, [47:43] zero
  input  logic [esp_pkg::IN_DW-1:0]   in_tdata,
  // [0] slow_tick
  input  logic                        in_tuser,
  // Result items.
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [15:0] velocity_drive
  output logic [esp_pkg::OUT_DW-1:0]  out_tdata,
  // [0] drive_saturated
  output logic                        out_tuser,
  // Register writes.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [esp_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [esp_pkg::CFG_DW-1:0]  cfg_data
);
  import esp_pkg::*;

  esp_cfg_t cfg;
  esp_cmd_t cmd;
  esp_sts_t sts;

  // Control registers; the datapath reads them directly.
  esp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The sequencer owns both handshakes and issues one command word a cycle.
  esp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath keeps all loop state and the result payload.
  esp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

/* rtl/esp_checker.sv */
// ----------------------------------------------------------------------------
// esp_checker: port-level checks for encoder_speed_pid_ramp
// Watches the top-level ports and flags handshake and sequencing faults.
// ----------------------------------------------------------------------------
module esp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [esp_pkg::OUT_DW-1:0]  out_tdata,
  input logic                        out_tuser
);
  import esp_pkg::*;

  // Right after reset the block is empty and ready.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not empty and ready after reset");

  // An offered result stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before it was taken");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Every accepted item occupies the block through its sum, ramp and output states.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("input taken again before the item was worked");

endmodule

bind encoder_speed_pid_ramp esp_checker u_esp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
